[sv/rgb_gaussian_blur_3x3_core_macros.svh]
// Assertion macros for the checker file of the blur core.
`ifndef RGB_GAUSSIAN_BLUR_3X3_CORE_MACROS_SVH
`define RGB_GAUSSIAN_BLUR_3X3_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RGBGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RGBGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rgbgb_pkg.sv]
// Package with constants, types and helper functions of the blur core.
`timescale 1ns / 1ps
`default_nettype none
package rgbgb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int unsigned MIN_DIM = 3;

  localparam int REG_W     = 12;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);
  localparam int CMP_W  = ((ROW_W > REG_W) ? ROW_W : REG_W) + 1;

  localparam int NUM_CH   = 3;
  localparam int CH_W     = 8;
  localparam int PIX_W    = NUM_CH * CH_W;
  localparam int VS_W     = CH_W + 2;
  localparam int HS_W     = CH_W + 4;
  localparam int DIV_SH   = 4;
  localparam int NUM_TAPS = 3;

  localparam logic [REG_W-1:0] RST_IMAGE_WIDTH  = REG_W'(640);
  localparam logic [REG_W-1:0] RST_IMAGE_HEIGHT = REG_W'(480);
  localparam logic [REG_W-1:0] RST_BAND_FIRST   = REG_W'(0);
  localparam logic [REG_W-1:0] RST_BAND_END     = REG_W'(2048);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_BAND_FIRST_ROW,
    REG_BAND_END_ROW
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [NUM_CH-1:0][VS_W-1:0] vsum_t;

  typedef struct packed {
    logic [REG_W-1:0] image_width;
    logic [REG_W-1:0] image_height;
    logic [REG_W-1:0] band_first_row;
    logic [REG_W-1:0] band_end_row;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] x;
    pixel_t           pix;
    logic             emit;
    logic             blur;
    logic             last;
  } item_t;

  typedef struct packed {
    pixel_t up;
    pixel_t mid;
  } line_t;

  typedef struct packed {
    pixel_t up;
    pixel_t mid;
    pixel_t low;
  } column_t;

  function automatic int unsigned clamp_dim(input logic [REG_W-1:0] v, input int unsigned maxv);
    int unsigned vi;
    vi = 32'(v);
    if (vi < MIN_DIM) begin
      vi = MIN_DIM;
    end else if (vi > maxv) begin
      vi = maxv;
    end
    return vi;
  endfunction

  function automatic vsum_t col_sum(input column_t c);
    vsum_t s;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s[ch] = VS_W'(c.up[ch*CH_W +: CH_W]) + (VS_W'(c.mid[ch*CH_W +: CH_W]) << 1) +
              VS_W'(c.low[ch*CH_W +: CH_W]);
    end
    return s;
  endfunction

  function automatic pixel_t blur_sum(input vsum_t a, input vsum_t b, input vsum_t c);
    logic [HS_W-1:0] s;
    pixel_t p;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s = HS_W'(a[ch]) + (HS_W'(b[ch]) << 1) + HS_W'(c[ch]);
      p[ch*CH_W +: CH_W] = s[DIV_SH +: CH_W];
    end
    return p;
  endfunction

endpackage
`default_nettype wire

[sv/rgbgb_regs.sv]
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module rgbgb_regs import rgbgb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;
  cfg_t     cfg_r;
  cfg_t     cfg_nxt;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
  assign wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_IMAGE_WIDTH:    cfg_nxt.image_width    = pwdata[REG_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_nxt.image_height   = pwdata[REG_W-1:0];
        REG_BAND_FIRST_ROW: cfg_nxt.band_first_row = pwdata[REG_W-1:0];
        REG_BAND_END_ROW:   cfg_nxt.band_end_row   = pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:    prdata = DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT:   prdata = DATA_W'(cfg_r.image_height);
      REG_BAND_FIRST_ROW: prdata = DATA_W'(cfg_r.band_first_row);
      REG_BAND_END_ROW:   prdata = DATA_W'(cfg_r.band_end_row);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= RST_IMAGE_WIDTH;
      cfg_r.image_height   <= RST_IMAGE_HEIGHT;
      cfg_r.band_first_row <= RST_BAND_FIRST;
      cfg_r.band_end_row   <= RST_BAND_END;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[sv/rgbgb_ctrl.sv]
// Raster position, drain and border/band decisions for each accepted transaction.
`timescale 1ns / 1ps
`default_nettype none
module rgbgb_ctrl import rgbgb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   accept,
  input  wire pixel_t pix_in,
  input  wire logic   flush,
  output logic        item_valid,
  output item_t       item
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  logic [WD_W-1:0]   w;
  logic [HT_W-1:0]   h;
  logic              drain;
  logic [COL_W:0]    col_inc;
  logic              wrap;
  logic [WD_W-1:0]   ox;
  logic [ROW_W-1:0]  oy;
  logic              oy_neg;
  logic              emit;
  logic              blur;
  logic              last;

  always_comb begin
    w       = WD_W'(clamp_dim(cfg.image_width, MAX_WIDTH));
    h       = HT_W'(clamp_dim(cfg.image_height, MAX_HEIGHT));
    drain   = CMP_W'(row_r) >= CMP_W'(h);
    col_inc = (COL_W + 1)'(col_r) + (COL_W + 1)'(1);
    wrap    = CMP_W'(col_inc) >= CMP_W'(w);

    if (col_r == '0) begin
      ox     = w - WD_W'(1);
      oy     = row_r - ROW_W'(2);
      oy_neg = row_r < ROW_W'(2);
    end else begin
      ox     = WD_W'(col_r) - WD_W'(1);
      oy     = row_r - ROW_W'(1);
      oy_neg = row_r == '0;
    end

    blur = !oy_neg && (oy != '0) && (CMP_W'(oy) + CMP_W'(2) <= CMP_W'(h)) &&
           (ox != '0) && (CMP_W'(ox) + CMP_W'(2) <= CMP_W'(w)) &&
           (CMP_W'(oy) >= CMP_W'(cfg.band_first_row)) &&
           (CMP_W'(oy) < CMP_W'(cfg.band_end_row));
    last = !oy_neg && (CMP_W'(oy) + CMP_W'(1) == CMP_W'(h)) &&
           (CMP_W'(ox) + CMP_W'(1) == CMP_W'(w));

    col_nxt    = col_r;
    row_nxt    = row_r;
    pend_nxt   = pend_r;
    item_valid = 1'b0;
    emit       = 1'b0;
    priority if (!accept) begin
      item_valid = 1'b0;
    end else if (drain && (pend_r == '0)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (drain || !flush) begin
      item_valid = 1'b1;
      if (wrap) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
      if (drain) begin
        emit     = 1'b1;
        pend_nxt = pend_r - PEND_W'(1);
        if (pend_r == PEND_W'(1)) begin
          col_nxt = '0;
          row_nxt = '0;
        end
      end else if (CMP_W'(pend_r) < CMP_W'(w) + CMP_W'(1)) begin
        pend_nxt = pend_r + PEND_W'(1);
      end else begin
        emit = 1'b1;
      end
    end else begin
      item_valid = 1'b0;
    end

    item.x    = col_r;
    item.pix  = drain ? '0 : pix_in;
    item.emit = emit;
    item.blur = blur;
    item.last = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/rgbgb_line_mem.sv]
// Dual line store RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rgbgb_line_mem import rgbgb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  output line_t                 rd_data,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire line_t            wr_data
);

  line_t mem [MAX_WIDTH];
  line_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[sv/rgbgb_cell.sv]
// One window column cell: holds three pixels and their vertical 1-2-1 sums.
`timescale 1ns / 1ps
`default_nettype none
module rgbgb_cell import rgbgb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    shift,
  input  wire column_t col_in,
  input  wire vsum_t   sum_in,
  output column_t      col_out,
  output vsum_t        sum_out
);

  column_t col_r;
  vsum_t   sum_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
      sum_r <= sum_in;
    end
  end

  assign col_out = col_r;
  assign sum_out = sum_r;

endmodule
`default_nettype wire

[sv/rgb_gaussian_blur_3x3_core.sv]
// Top level of the 3x3 binomial blur core for an RGB888 raster stream.
// Throughput: one pixel transaction per clock, sustained while out_tready does not stall the output.
// Pipeline: a result passes through the stage-1 registers and the window cells into the output register;
//   the output stream runs image_width + 1 pixels behind the input stream.
// Line stores: one 2048 x 48 RAM, one read and one write per clock, read data registered.
// Reset (rst_n low, synchronous): counters, valid bits and configuration registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none
module rgb_gaussian_blur_3x3_core import rgbgb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [PIX_W-1:0]  in_tdata,   // red_in, green_in, blue_in
  input  wire logic              in_tuser,   // flush
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [PIX_W-1:0]  out_tdata,  // red_out, green_out, blue_out
  output logic                   out_tlast,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t    cfg;
  logic    accept;
  logic    item_valid;
  item_t   item;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    fwd_r;
  line_t   fwd_data_r;
  line_t   rd_data;
  line_t   s1_line;
  line_t   wr_data;
  logic    s1_adv;
  logic    s1_free;

  logic    s2_valid_r, s2_valid_nxt;
  logic    s2_emit_r;
  logic    s2_blur_r;
  logic    s2_last_r;
  logic    s2_adv;
  logic    s2_free;

  logic    out_valid_r, out_valid_nxt;
  pixel_t  out_data_r;
  logic    out_last_r;
  logic    out_free;
  logic    out_load;

  column_t col_in;
  vsum_t   sum_in;
  column_t win_col [NUM_TAPS];
  vsum_t   win_sum [NUM_TAPS];
  pixel_t  result;

  assign cfg_pready = 1'b1;

  rgbgb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s2_adv    = s2_valid_r && (!s2_emit_r || out_free);
  assign s2_free   = !s2_valid_r || s2_adv;
  assign s1_adv    = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s1_adv;
  assign in_tready = s1_free;
  assign accept    = in_tvalid && in_tready;
  assign out_load  = s2_adv && s2_emit_r;

  rgbgb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .accept     (accept),
    .pix_in     (in_tdata),
    .flush      (in_tuser),
    .item_valid (item_valid),
    .item       (item)
  );

  assign s1_line     = fwd_r ? fwd_data_r : rd_data;
  assign wr_data.up  = s1_line.mid;
  assign wr_data.mid = s1_item_r.pix;

  rgbgb_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (item_valid),
    .rd_addr (item.x),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_item_r.x),
    .wr_data (wr_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (item_valid) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      s1_item_r  <= item;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (item_valid) begin
        fwd_r <= s1_adv && (item.x == s1_item_r.x);
      end
    end
  end

  assign col_in.up  = s1_line.up;
  assign col_in.mid = s1_line.mid;
  assign col_in.low = s1_item_r.pix;
  assign sum_in     = col_sum(col_in);

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      rgbgb_cell u_cell (
        .clk     (clk),
        .shift   (s1_adv),
        .col_in  (col_in),
        .sum_in  (sum_in),
        .col_out (win_col[k]),
        .sum_out (win_sum[k])
      );
    end else begin : g_tail
      rgbgb_cell u_cell (
        .clk     (clk),
        .shift   (s1_adv),
        .col_in  (win_col[k-1]),
        .sum_in  (win_sum[k-1]),
        .col_out (win_col[k]),
        .sum_out (win_sum[k])
      );
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s1_adv) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_adv) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_emit_r <= s1_item_r.emit;
      s2_blur_r <= s1_item_r.blur;
      s2_last_r <= s1_item_r.last;
    end
  end

  assign result = s2_blur_r ? blur_sum(win_sum[0], win_sum[1], win_sum[2]) : win_col[1].mid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
      out_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

[sv/rgbgb_checker.sv]
// Port-level checker for the blur core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_gaussian_blur_3x3_core_macros.svh"
module rgbgb_checker import rgbgb_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [PIX_W-1:0]  out_tdata,
  input wire logic              out_tlast,
  input wire logic              cfg_psel,
  input wire logic              cfg_penable,
  input wire logic              cfg_pwrite,
  input wire logic [ADDR_W-1:0] cfg_paddr,
  input wire logic [DATA_W-1:0] cfg_pwdata,
  input wire logic [DATA_W-1:0] cfg_prdata,
  input wire logic              cfg_pready
);

  logic              cfg_wr;
  logic [DATA_W-1:0] cfg_wr_word;
  logic              out_stall;
  logic              out_free;
  logic [PIX_W:0]    out_bus;

  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_wr_word = DATA_W'(cfg_pwdata[REG_W-1:0]);
  assign out_stall   = out_tvalid && !out_tready;
  assign out_free    = !out_tvalid || out_tready;
  assign out_bus     = {out_tlast, out_tdata};

  property p_cfg_readback;
    cfg_wr ##1 (!cfg_wr && $stable(cfg_paddr)) |-> cfg_prdata == $past(cfg_wr_word);
  endproperty

  `RGBGB_ASSERT_ALWAYS(a_reset_drops_output, !rst_n |=> !out_tvalid, "output valid after reset")
  `RGBGB_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_bus), "stalled output changed")
  `RGBGB_ASSERT(a_ready_when_drained, out_free |-> in_tready, "input stalled while output can move")
  `RGBGB_ASSERT(a_cfg_readback, p_cfg_readback, "register readback mismatch")

endmodule

bind rgb_gaussian_blur_3x3_core rgbgb_checker u_checker (.*);
`default_nettype wire
